// ===== design/dspt_pkg.sv =====
package dspt_pkg;

  localparam int unsigned PosW  = 32;
  localparam int unsigned CompW = 16;
  localparam int unsigned MsW   = 10;
  localparam int unsigned ScaleW = CompW + MsW;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW = 272;
  localparam int unsigned OutDataW = 160;
  localparam int unsigned SlotNumW = 6;
  localparam int unsigned LiveW = 7;

  localparam logic [CfgIdxW-1:0] RegLoopMode = 3'd0;
  localparam logic [CfgIdxW-1:0] RegEmitPeriod = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBorderX = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBorderY = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBorderZ = 3'd4;

  typedef struct packed {
    logic signed [PosW-1:0]  px;
    logic signed [PosW-1:0]  py;
    logic signed [PosW-1:0]  pz;
    logic signed [CompW-1:0] red;
    logic signed [CompW-1:0] green;
    logic signed [CompW-1:0] blue;
    logic signed [CompW-1:0] speed;
    logic                    live;
  } slot_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_UP,
    CELL_FROM_DN,
    CELL_LOAD
  } cell_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LIM_MUL,
    ST_LIM_SUM,
    ST_KILL_MUL,
    ST_KILL_CMP,
    ST_TIMER,
    ST_SEARCH,
    ST_INSERT,
    ST_MOV_SCALE,
    ST_MOV_MUL,
    ST_MOV_OUT
  } state_e;

endpackage

// ===== design/dspt_cell.sv =====
module dspt_cell #(
  parameter logic [31:0] RstPy = 32'd0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dspt_pkg::cell_op_e op_i,
  input  dspt_pkg::slot_t  up_i,
  input  dspt_pkg::slot_t  dn_i,
  input  dspt_pkg::slot_t  ld_i,
  output dspt_pkg::slot_t  slot_o
);
  import dspt_pkg::*;

  localparam slot_t RstSlot = '{px: '0, py: RstPy, pz: '0, red: '0, green: '0, blue: '0,
                                speed: '0, live: 1'b0};

  slot_t slot_q, slot_d;

  always_comb begin
    case (op_i)
      CELL_FROM_UP: slot_d = up_i;
      CELL_FROM_DN: slot_d = dn_i;
      CELL_LOAD:    slot_d = ld_i;
      default:      slot_d = slot_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= RstSlot;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

// ===== design/depth_sorted_particle_table.sv =====
// One input item per frame produces SLOTS output items, slot 0 (deepest) first,
// the last one flagged on m_axis_tlast. Slots live in a chain of cells that shift
// towards or away from each other for removal and depth-ordered insertion. A frame
// accepts the item, runs the border check and removal in loop mode, updates the timer,
// may search for the insertion point and load the candidate, then moves and outputs
// each slot in turn; the shared squaring multipliers and the motion multiplier chain
// are used slot by slot. Output back-pressure stalls the motion and output phase.
module depth_sorted_particle_table #(
  parameter int unsigned SLOTS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dspt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dspt_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // move_x, move_y, move_z, frame_ms, cand_x, cand_y, cand_z, cand_speed,
  // cand_red, cand_green, cand_blue, zero pad
  input  logic [dspt_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // slot_number, out_x, out_y, out_z, out_red, out_green, out_blue, is_live,
  // live_total, zero pad
  output logic [dspt_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast
);
  import dspt_pkg::*;

  localparam int unsigned CntW = $clog2(SLOTS + 1);
  localparam int unsigned IdxW = $clog2(SLOTS);

  state_e state_q, state_d;

  logic                    loop_mode_q;
  logic [15:0]             period_q;
  logic signed [PosW-1:0]  bx_q, by_q, bz_q;
  logic [15:0]             acc_q, acc_d;
  logic [LiveW-1:0]        live_q, live_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [CntW-1:0]         top_q, top_d;
  logic [CntW-1:0]         at_q, at_d;

  logic signed [PosW-1:0]  mx_q, my_q, mz_q;
  logic [MsW-1:0]          ms_q;
  slot_t                   cand_q;

  logic [63:0]             sqa_q, sqb_q, sqc_q;
  logic [63:0]             lim_q;
  logic signed [ScaleW-1:0] scale_q;
  logic signed [PosW+ScaleW-1:0] prx_q, pry_q, prz_q;

  logic                    out_valid_q;
  logic [OutDataW-1:0]     out_data_q;
  logic                    out_last_q;

  slot_t                   cells [SLOTS];
  cell_op_e                ops [SLOTS];
  slot_t                   sel;
  slot_t                   ld_bus;
  slot_t                   moved;

  logic                    in_fire;
  logic                    out_free;
  logic                    kill;
  logic [65:0]             len_sq;
  logic [16:0]             acc_sum;
  logic [15:0]             acc_sat;
  logic [PosW-1:0]         ma, mb, mc;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign sel    = cells[cnt_q[IdxW-1:0]];
  assign len_sq = {2'b00, sqa_q} + {2'b00, sqb_q} + {2'b00, sqc_q};
  assign kill   = (len_sq > {2'b00, lim_q});

  assign acc_sum = {1'b0, acc_q} + {7'd0, ms_q};
  assign acc_sat = acc_sum[16] ? 16'hFFFF : acc_sum[15:0];

  function automatic logic [PosW-1:0] mag(input logic signed [PosW-1:0] v);
    mag = v[PosW-1] ? PosW'(-v) : PosW'(v);
  endfunction

  function automatic logic signed [PosW-1:0] advance(input logic signed [PosW-1:0] pos,
                                                      input logic signed [PosW+ScaleW-1:0] pr);
    logic signed [PosW+ScaleW:0] rnd;
    logic signed [PosW+ScaleW:0] sum;
    rnd = (PosW+ScaleW+1)'(pr) + (PosW+ScaleW+1)'(2048);
    sum = (rnd >>> 12) + (PosW+ScaleW+1)'(pos);
    if (sum > (PosW+ScaleW+1)'(32'sh7FFFFFFF)) advance = 32'sh7FFFFFFF;
    else if (sum < -(PosW+ScaleW+1)'(64'sh80000000)) advance = 32'sh80000000;
    else advance = sum[PosW-1:0];
  endfunction

  always_comb begin
    moved    = sel;
    moved.px = advance(sel.px, prx_q);
    moved.py = advance(sel.py, pry_q);
    moved.pz = advance(sel.pz, prz_q);
    ld_bus   = (state_q == ST_INSERT) ? cand_q : moved;
  end

  always_comb begin
    if (state_q == ST_LIM_MUL) begin
      ma = mag(bx_q);
      mb = mag(by_q);
      mc = mag(bz_q);
    end else begin
      ma = mag(sel.px);
      mb = mag(sel.py);
      mc = mag(sel.pz);
    end
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    localparam logic [31:0] RstPy = 32'((g * 65536 + 5) / 10);
    slot_t up, dn;
    assign up = (g == SLOTS - 1) ? slot_t'('0) : cells[(g == SLOTS - 1) ? g : g + 1];
    assign dn = (g == 0) ? slot_t'('0) : cells[(g == 0) ? g : g - 1];

    always_comb begin
      ops[g] = CELL_HOLD;
      case (state_q)
        ST_KILL_CMP: begin
          if (kill && CntW'(g) >= cnt_q) ops[g] = CELL_FROM_UP;
        end
        ST_INSERT: begin
          if (CntW'(g) == at_q) ops[g] = CELL_LOAD;
          else if (CntW'(g) > at_q && CntW'(g) <= top_q) ops[g] = CELL_FROM_DN;
        end
        ST_MOV_OUT: begin
          if (out_free && CntW'(g) == cnt_q) ops[g] = CELL_LOAD;
        end
        default: ops[g] = CELL_HOLD;
      endcase
    end

    dspt_cell #(.RstPy(RstPy)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .op_i   (ops[g]),
      .up_i   (up),
      .dn_i   (dn),
      .ld_i   (ld_bus),
      .slot_o (cells[g])
    );
  end

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    live_d  = live_q;
    cnt_d   = cnt_q;
    top_d   = top_q;
    at_d    = at_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cnt_d   = '0;
          state_d = loop_mode_q ? ST_LIM_MUL : ST_TIMER;
        end
      end
      ST_LIM_MUL: state_d = ST_LIM_SUM;
      ST_LIM_SUM: state_d = ST_KILL_MUL;
      ST_KILL_MUL: begin
        if (cnt_q == CntW'(SLOTS)) state_d = ST_TIMER;
        else if (!sel.live) cnt_d = cnt_q + 1'b1;
        else state_d = ST_KILL_CMP;
      end
      ST_KILL_CMP: begin
        if (kill) begin
          if (live_q != '0) live_d = live_q - 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
        state_d = ST_KILL_MUL;
      end
      ST_TIMER: begin
        cnt_d   = '0;
        state_d = ST_MOV_SCALE;
        if (acc_sat > period_q) begin
          acc_d = '0;
          if (live_q < LiveW'(SLOTS - 1)) begin
            live_d  = live_q + 1'b1;
            top_d   = CntW'(live_q) + 1'b1;
            state_d = ST_SEARCH;
          end
        end else begin
          acc_d = acc_sat;
        end
      end
      ST_SEARCH: begin
        if (cnt_q == top_q) begin
          at_d    = top_q;
          state_d = ST_INSERT;
        end else if (!sel.live || sel.pz < cand_q.pz) begin
          at_d    = cnt_q;
          state_d = ST_INSERT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_INSERT: begin
        cnt_d   = '0;
        state_d = ST_MOV_SCALE;
      end
      ST_MOV_SCALE: state_d = ST_MOV_MUL;
      ST_MOV_MUL:   state_d = ST_MOV_OUT;
      ST_MOV_OUT: begin
        if (out_free) begin
          cnt_d   = cnt_q + 1'b1;
          state_d = (cnt_q == CntW'(SLOTS - 1)) ? ST_IDLE : ST_MOV_SCALE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      live_q      <= '0;
      cnt_q       <= '0;
      top_q       <= '0;
      at_q        <= '0;
      loop_mode_q <= 1'b1;
      period_q    <= 16'd4;
      bx_q        <= '0;
      by_q        <= '0;
      bz_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      live_q  <= live_d;
      cnt_q   <= cnt_d;
      top_q   <= top_d;
      at_q    <= at_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegLoopMode:   loop_mode_q <= cfg_data_i[0];
          RegEmitPeriod: period_q    <= cfg_data_i[15:0];
          RegBorderX:    bx_q        <= cfg_data_i;
          RegBorderY:    by_q        <= cfg_data_i;
          RegBorderZ:    bz_q        <= cfg_data_i;
          default:       ;
        endcase
      end
      if (state_q == ST_MOV_OUT && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mx_q         <= s_axis_tdata[31:0];
      my_q         <= s_axis_tdata[63:32];
      mz_q         <= s_axis_tdata[95:64];
      ms_q         <= s_axis_tdata[105:96];
      cand_q.px    <= s_axis_tdata[137:106];
      cand_q.py    <= s_axis_tdata[169:138];
      cand_q.pz    <= s_axis_tdata[201:170];
      cand_q.speed <= s_axis_tdata[217:202];
      cand_q.red   <= s_axis_tdata[233:218];
      cand_q.green <= s_axis_tdata[249:234];
      cand_q.blue  <= s_axis_tdata[265:250];
      cand_q.live  <= 1'b1;
    end
    sqa_q <= {32'd0, ma} * {32'd0, ma};
    sqb_q <= {32'd0, mb} * {32'd0, mb};
    sqc_q <= {32'd0, mc} * {32'd0, mc};
    if (state_q == ST_LIM_SUM) lim_q <= len_sq[63:0];
    scale_q <= ScaleW'(sel.speed) * $signed({1'b0, ms_q});
    prx_q <= (PosW+ScaleW)'(mx_q) * (PosW+ScaleW)'(scale_q);
    pry_q <= (PosW+ScaleW)'(my_q) * (PosW+ScaleW)'(scale_q);
    prz_q <= (PosW+ScaleW)'(mz_q) * (PosW+ScaleW)'(scale_q);
    if (state_q == ST_MOV_OUT && out_free) begin
      out_data_q <= {2'b00, live_d, moved.live, moved.blue, moved.green, moved.red,
                     moved.pz, moved.py, moved.px, SlotNumW'(cnt_q)};
      out_last_q <= (cnt_q == CntW'(SLOTS - 1));
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule
